[sv/range_add_historic_max_tree_core_macros.svh]
// Assertion shorthands for the range add / historic max tree.
// Each expects signals named clock and reset in the using module.
`ifndef RANGE_ADD_HISTORIC_MAX_TREE_CORE_MACROS_SVH
`define RANGE_ADD_HISTORIC_MAX_TREE_CORE_MACROS_SVH

// same-cycle implication
`define RAHM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RAHM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rahm_pkg.sv]
package rahm_pkg;

   // tree geometry
   localparam int LEAF_COUNT  = 1024;
   localparam int SUM_WIDTH   = 48;
   localparam int NODE_DEPTH  = 2 * LEAF_COUNT;
   localparam int NODE_AW     = $clog2(NODE_DEPTH);
   localparam int STACK_DEPTH = $clog2(LEAF_COUNT) + 1;
   localparam int SP_W        = $clog2(STACK_DEPTH);

   // field widths
   localparam int POS_W = 11;
   localparam int VAL_W = 32;
   localparam int OUT_W = 47;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic signed [SUM_WIDTH-1:0] sum_type;

   localparam sum_type WORD_MAX = sum_type'({1'b0, {(SUM_WIDTH-1){1'b1}}});
   localparam sum_type WORD_MIN = sum_type'({1'b1, {(SUM_WIDTH-1){1'b0}}});

   // one node: current max, pending add, historic max, historic pending add
   typedef struct packed {
      sum_type cur;
      sum_type pend;
      sum_type hist;
      sum_type hpend;
   } word_type;

   typedef enum logic [1:0] {
      PHASE_ENTER,
      PHASE_LEFT_DONE,
      PHASE_RIGHT_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ADDR_NODE,
      ADDR_LEFT,
      ADDR_RIGHT,
      ADDR_CLEAR
   } addr_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_NODE,
      CAP_LEFT,
      CAP_RIGHT
   } cap_sel_type;

   typedef enum logic [2:0] {
      WR_COVER,
      WR_PUSH_NODE,
      WR_PUSH_LEFT,
      WR_PUSH_RIGHT,
      WR_PULL,
      WR_CLEAR
   } wr_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic         load_op;
      logic         rd_en;
      logic         wr_en;
      addr_sel_type addr_sel;
      cap_sel_type  cap_sel;
      wr_sel_type   wr_sel;
      logic         push_left;
      logic         push_right;
      logic         pop;
      logic         best_upd;
      logic         clear_start;
      logic         clear_step;
      logic         rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic      disjoint;
      logic      covered;
      phase_type phase;
      logic      sp_zero;
      logic      is_query;
      logic      clear_last;
   } status_type;

   // saturating add over the signed word range
   function automatic sum_type sat_add(sum_type a, sum_type b);
      logic [SUM_WIDTH:0] s;
      s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         return s[SUM_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return sum_type'(s[SUM_WIDTH-1:0]);
   endfunction

   function automatic sum_type bigger(sum_type a, sum_type b);
      return (a > b) ? a : b;
   endfunction

   // apply a parent's pending words to one child
   function automatic word_type push_child(word_type c, sum_type pa, sum_type hpa);
      word_type r;
      r.hist  = bigger(c.hist, sat_add(c.cur, hpa));
      r.hpend = bigger(c.hpend, sat_add(c.pend, hpa));
      r.cur   = sat_add(c.cur, pa);
      r.pend  = sat_add(c.pend, pa);
      return r;
   endfunction

endpackage

[sv/rahm_node_ram.sv]
module rahm_node_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 192
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= wdata;
      end
      if (read_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/rahm_datapath.sv]
`include "range_add_historic_max_tree_core_macros.svh"

module rahm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  rahm_pkg::cmd_type                 cmd,
   output rahm_pkg::status_type              status,
   input  logic                              req_func,
   input  logic [rahm_pkg::POS_W-1:0]        req_range_low,
   input  logic [rahm_pkg::POS_W-1:0]        req_range_high,
   input  logic signed [rahm_pkg::VAL_W-1:0] req_add_value,
   input  logic                              csr_we,
   input  logic [rahm_pkg::POS_W-1:0]        csr_wdata,
   output logic [rahm_pkg::OUT_W-1:0]        rsp_historic_max,
   output logic                              ram_we,
   output logic                              ram_re,
   output logic [rahm_pkg::NODE_AW-1:0]      ram_addr,
   output rahm_pkg::word_type                ram_wdata,
   input  rahm_pkg::word_type                ram_rdata
);

   typedef struct packed {
      logic [rahm_pkg::NODE_AW-1:0] node;
      logic [rahm_pkg::POS_W-1:0]   lo;
      logic [rahm_pkg::POS_W-1:0]   hi;
      rahm_pkg::phase_type          phase;
   } frame_type;

   logic                         func_ff;
   logic [rahm_pkg::POS_W-1:0]   qlo_ff;
   logic [rahm_pkg::POS_W-1:0]   qhi_ff;
   rahm_pkg::sum_type            val_ff;
   logic [rahm_pkg::POS_W-1:0]   leaves_ff;
   rahm_pkg::sum_type            best_ff;
   logic [rahm_pkg::OUT_W-1:0]   rsp_max_ff;
   rahm_pkg::word_type           node_q_ff;
   rahm_pkg::word_type           left_q_ff;
   rahm_pkg::word_type           right_q_ff;
   logic [rahm_pkg::SP_W-1:0]    sp_ff;
   logic [rahm_pkg::SP_W-1:0]    sp_up;
   frame_type                    stack_ff [rahm_pkg::STACK_DEPTH];
   logic [rahm_pkg::NODE_AW-1:0] clr_cnt_ff;

   frame_type                    top;
   logic [rahm_pkg::POS_W-1:0]   eff_leaves;
   logic [rahm_pkg::POS_W:0]     mid_sum;
   logic [rahm_pkg::POS_W-1:0]   mid;
   logic [rahm_pkg::NODE_AW-1:0] left_node;
   logic [rahm_pkg::NODE_AW-1:0] right_node;
   rahm_pkg::sum_type            cov_cur;
   rahm_pkg::sum_type            cov_pend;

   // clamp the row length to 1..LEAF_COUNT
   always_comb begin
      if (leaves_ff == '0) begin
         eff_leaves = rahm_pkg::POS_W'(1);
      end else if (leaves_ff > rahm_pkg::POS_W'(rahm_pkg::LEAF_COUNT)) begin
         eff_leaves = rahm_pkg::POS_W'(rahm_pkg::LEAF_COUNT);
      end else begin
         eff_leaves = leaves_ff;
      end
   end

   // current frame and its children
   assign top        = stack_ff[sp_ff];
   assign sp_up      = sp_ff + rahm_pkg::SP_W'(1);
   assign mid_sum    = {1'b0, top.lo} + {1'b0, top.hi};
   assign mid        = mid_sum[rahm_pkg::POS_W:1];
   assign left_node  = {top.node[rahm_pkg::NODE_AW-2:0], 1'b0};
   assign right_node = {top.node[rahm_pkg::NODE_AW-2:0], 1'b1};

   assign status.disjoint   = (qhi_ff < top.lo) || (top.hi < qlo_ff);
   assign status.covered    = (qlo_ff <= top.lo) && (top.hi <= qhi_ff);
   assign status.phase      = top.phase;
   assign status.sp_zero    = (sp_ff == '0);
   assign status.is_query   = (func_ff == rahm_pkg::FUNC_QUERY);
   assign status.clear_last = &clr_cnt_ff;

   // node memory address
   always_comb begin
      case (cmd.addr_sel)
         rahm_pkg::ADDR_NODE:  ram_addr = top.node;
         rahm_pkg::ADDR_LEFT:  ram_addr = left_node;
         rahm_pkg::ADDR_RIGHT: ram_addr = right_node;
         rahm_pkg::ADDR_CLEAR: ram_addr = clr_cnt_ff;
         default:              ram_addr = top.node;
      endcase
   end

   assign ram_we = cmd.wr_en;
   assign ram_re = cmd.rd_en;

   // full cover of an add
   assign cov_cur  = rahm_pkg::sat_add(node_q_ff.cur, val_ff);
   assign cov_pend = rahm_pkg::sat_add(node_q_ff.pend, val_ff);

   // write data select
   always_comb begin
      ram_wdata = '0;
      case (cmd.wr_sel)
         rahm_pkg::WR_COVER: begin
            ram_wdata.cur   = cov_cur;
            ram_wdata.pend  = cov_pend;
            ram_wdata.hist  = rahm_pkg::bigger(node_q_ff.hist, cov_cur);
            ram_wdata.hpend = rahm_pkg::bigger(node_q_ff.hpend, cov_pend);
         end
         rahm_pkg::WR_PUSH_NODE: begin
            ram_wdata.cur  = node_q_ff.cur;
            ram_wdata.hist = node_q_ff.hist;
         end
         rahm_pkg::WR_PUSH_LEFT: begin
            ram_wdata = rahm_pkg::push_child(left_q_ff, node_q_ff.pend, node_q_ff.hpend);
         end
         rahm_pkg::WR_PUSH_RIGHT: begin
            ram_wdata = rahm_pkg::push_child(right_q_ff, node_q_ff.pend, node_q_ff.hpend);
         end
         rahm_pkg::WR_PULL: begin
            ram_wdata.cur  = rahm_pkg::bigger(left_q_ff.cur, right_q_ff.cur);
            ram_wdata.hist = rahm_pkg::bigger(left_q_ff.hist, right_q_ff.hist);
         end
         default: ram_wdata = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         clr_cnt_ff <= '0;
         leaves_ff  <= rahm_pkg::POS_W'(rahm_pkg::LEAF_COUNT);
      end else begin
         if (csr_we) begin
            leaves_ff <= csr_wdata;
         end
         if (cmd.clear_start) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + rahm_pkg::NODE_AW'(1);
         end
         if (cmd.load_op) begin
            sp_ff <= '0;
         end else if (cmd.push_left || cmd.push_right) begin
            sp_ff <= sp_up;
         end else if (cmd.pop) begin
            sp_ff <= sp_ff - rahm_pkg::SP_W'(1);
         end
      end
   end

   // operation, traversal stack and captured node words
   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         func_ff     <= req_func;
         qlo_ff      <= req_range_low;
         qhi_ff      <= req_range_high;
         val_ff      <= rahm_pkg::sum_type'(req_add_value);
         best_ff     <= '0;
         stack_ff[0] <= '{node: rahm_pkg::NODE_AW'(1), lo: rahm_pkg::POS_W'(1),
                          hi: eff_leaves, phase: rahm_pkg::PHASE_ENTER};
      end
      if (cmd.push_left) begin
         stack_ff[sp_ff].phase <= rahm_pkg::PHASE_LEFT_DONE;
         stack_ff[sp_up]       <= '{node: left_node, lo: top.lo, hi: mid,
                                    phase: rahm_pkg::PHASE_ENTER};
      end
      if (cmd.push_right) begin
         stack_ff[sp_ff].phase <= rahm_pkg::PHASE_RIGHT_DONE;
         stack_ff[sp_up]       <= '{node: right_node, lo: mid + rahm_pkg::POS_W'(1),
                                    hi: top.hi, phase: rahm_pkg::PHASE_ENTER};
      end
      if (cmd.best_upd) begin
         best_ff <= rahm_pkg::bigger(best_ff, node_q_ff.hist);
      end
      if (cmd.rsp_load) begin
         rsp_max_ff <= best_ff[rahm_pkg::OUT_W-1:0];
      end
      case (cmd.cap_sel)
         rahm_pkg::CAP_NODE:  node_q_ff  <= ram_rdata;
         rahm_pkg::CAP_LEFT:  left_q_ff  <= ram_rdata;
         rahm_pkg::CAP_RIGHT: right_q_ff <= ram_rdata;
         default: ;
      endcase
   end

   assign rsp_historic_max = rsp_max_ff;

   `RAHM_ASSERT_NOW(a_cap_after_read, cmd.cap_sel != rahm_pkg::CAP_NONE, $past(cmd.rd_en), "capture without read")
   `RAHM_ASSERT_NOW(a_stack_room, cmd.push_left || cmd.push_right, sp_ff < rahm_pkg::SP_W'(rahm_pkg::STACK_DEPTH - 1), "traversal stack overflow")
   `RAHM_ASSERT_NEXT(a_load_init, cmd.load_op, sp_ff == '0 && best_ff == '0, "operation start not initialized")

endmodule

[sv/rahm_ctrl.sv]
`include "range_add_historic_max_tree_core_macros.svh"

module rahm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_we,
   input  rahm_pkg::status_type status,
   output rahm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT,
      ST_COVER_RD,
      ST_COVER_UPD,
      ST_PUSH_RD0,
      ST_PUSH_RD1,
      ST_PUSH_RD2,
      ST_PUSH_WR1,
      ST_PUSH_WR2,
      ST_PULL_RD0,
      ST_PULL_RD1,
      ST_PULL_WR,
      ST_POP,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !csr_we;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en      = 1'b1;
            cmd.addr_sel   = rahm_pkg::ADDR_CLEAR;
            cmd.wr_sel     = rahm_pkg::WR_CLEAR;
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_op = 1'b1;
               state_in    = ST_VISIT;
            end
         end
         ST_VISIT: begin
            case (status.phase)
               rahm_pkg::PHASE_ENTER: begin
                  if (status.disjoint) begin
                     state_in = ST_POP;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = rahm_pkg::ADDR_NODE;
                     state_in     = status.covered ? ST_COVER_RD : ST_PUSH_RD0;
                  end
               end
               rahm_pkg::PHASE_LEFT_DONE: begin
                  cmd.push_right = 1'b1;
               end
               rahm_pkg::PHASE_RIGHT_DONE: begin
                  if (status.is_query) begin
                     state_in = ST_POP;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = rahm_pkg::ADDR_LEFT;
                     state_in     = ST_PULL_RD0;
                  end
               end
               default: state_in = ST_POP;
            endcase
         end
         ST_COVER_RD: begin
            cmd.cap_sel = rahm_pkg::CAP_NODE;
            state_in    = ST_COVER_UPD;
         end
         ST_COVER_UPD: begin
            if (status.is_query) begin
               cmd.best_upd = 1'b1;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.addr_sel = rahm_pkg::ADDR_NODE;
               cmd.wr_sel   = rahm_pkg::WR_COVER;
            end
            state_in = ST_POP;
         end
         // push-down: read node and both children, then write all three
         ST_PUSH_RD0: begin
            cmd.cap_sel  = rahm_pkg::CAP_NODE;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_LEFT;
            state_in     = ST_PUSH_RD1;
         end
         ST_PUSH_RD1: begin
            cmd.cap_sel  = rahm_pkg::CAP_LEFT;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_RIGHT;
            state_in     = ST_PUSH_RD2;
         end
         ST_PUSH_RD2: begin
            cmd.cap_sel  = rahm_pkg::CAP_RIGHT;
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_NODE;
            cmd.wr_sel   = rahm_pkg::WR_PUSH_NODE;
            state_in     = ST_PUSH_WR1;
         end
         ST_PUSH_WR1: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_LEFT;
            cmd.wr_sel   = rahm_pkg::WR_PUSH_LEFT;
            state_in     = ST_PUSH_WR2;
         end
         ST_PUSH_WR2: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = rahm_pkg::ADDR_RIGHT;
            cmd.wr_sel    = rahm_pkg::WR_PUSH_RIGHT;
            cmd.push_left = 1'b1;
            state_in      = ST_VISIT;
         end
         // pull-up after an add: recompute maxima from the children
         ST_PULL_RD0: begin
            cmd.cap_sel  = rahm_pkg::CAP_LEFT;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_RIGHT;
            state_in     = ST_PULL_RD1;
         end
         ST_PULL_RD1: begin
            cmd.cap_sel = rahm_pkg::CAP_RIGHT;
            state_in    = ST_PULL_WR;
         end
         ST_PULL_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = rahm_pkg::ADDR_NODE;
            cmd.wr_sel   = rahm_pkg::WR_PULL;
            state_in     = ST_POP;
         end
         ST_POP: begin
            if (status.sp_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_VISIT;
            end
         end
         ST_DONE: begin
            if (!status.is_query) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      // a register write restarts the clearing pass
      if (csr_we) begin
         cmd             = '0;
         cmd.clear_start = 1'b1;
         state_in        = ST_CLEAR;
      end
   end

   // result slot
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RAHM_ASSERT_NEXT(a_accept_visit, req_valid && req_ready, state_ff == ST_VISIT, "accepted item did not start traversal")
   `RAHM_ASSERT_NOW(a_one_port, cmd.rd_en, !cmd.wr_en, "read and write in one cycle")
   `RAHM_ASSERT_NEXT(a_csr_clear, csr_we, state_ff == ST_CLEAR, "register write without clearing pass")
   `RAHM_ASSERT_NOW(a_rsp_slot, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwrites pending result")

endmodule

[sv/range_add_historic_max_tree_core.sv]
// Range add / historic maximum segment tree over positions 1..active_leaves.
// Input channel (req_*): func 0 adds req_add_value to every position of
// [req_range_low, req_range_high]; func 1 asks for the highest value any
// position of that interval ever held. Adds give no result; each query gives
// one rsp_historic_max transfer on the rsp_* channel.
// One item is processed at a time; req_ready is high only while idle.
// Each item walks the single-port node memory depth first: a disjoint node
// needs no memory access, a fully covered node is read and then updated
// (add) or folded into the result (query), and a partly covered node is
// read with both children and all three are written back; after an add it
// is rewritten from its children once both of them have been visited.
// The result sits in an output register: a stalled receiver does not block
// the next item, only the completion of a following query.
// Reset and every csr_we write start a clearing pass over all node memory
// words, during which no item is taken; csr_wdata sets active_leaves (0 acts
// as 1, above 1024 acts as 1024).
module range_add_historic_max_tree_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [rahm_pkg::POS_W-1:0]        req_range_low,
   input  logic [rahm_pkg::POS_W-1:0]        req_range_high,
   input  logic signed [rahm_pkg::VAL_W-1:0] req_add_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rahm_pkg::OUT_W-1:0]        rsp_historic_max,
   input  logic                              csr_we,
   input  logic [rahm_pkg::POS_W-1:0]        csr_wdata
);

   rahm_pkg::cmd_type            cmd;
   rahm_pkg::status_type         status;
   logic                         ram_we;
   logic                         ram_re;
   logic [rahm_pkg::NODE_AW-1:0] ram_addr;
   rahm_pkg::word_type           ram_wdata;
   rahm_pkg::word_type           ram_rdata;

   rahm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .status    (status),
      .cmd       (cmd)
   );

   rahm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .req_add_value    (req_add_value),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_historic_max (rsp_historic_max),
      .ram_we           (ram_we),
      .ram_re           (ram_re),
      .ram_addr         (ram_addr),
      .ram_wdata        (ram_wdata),
      .ram_rdata        (ram_rdata)
   );

   rahm_node_ram #(
      .DEPTH (rahm_pkg::NODE_DEPTH),
      .WIDTH ($bits(rahm_pkg::word_type))
   ) u_node_ram (
      .clock    (clock),
      .write_en (ram_we),
      .read_en  (ram_re),
      .addr     (ram_addr),
      .wdata    (ram_wdata),
      .rdata    (ram_rdata)
   );

endmodule
